@@ hw/rtl/pdws_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PWM divider/wrap solver: widths, register indexes, the item record
// that travels down the pipeline. Used by pdws_unit and pwm_divider_wrap_duty_solver.
package pdws_pkg;

    localparam int CLK_W   = 28;   // source clock register
    localparam int TGT_W   = 20;   // target after the clamp to max_freq_hz
    localparam int DUTY_W  = 7;    // duty after saturation to 100
    localparam int DIV_W   = 8;    // internal divider number, covers dividers up to 255
    localparam int NUM_W   = 28;   // deviation numerator, below target * divider
    localparam int DEN_W   = 24;   // deviation denominator, quotient * divider when valid
    localparam int WRAP_W  = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAX_DIVIDER = 29;
    localparam int DEF_MIN_WRAP    = 100;

    localparam logic [CLK_W-1:0] CLK_RESET  = 28'd125000000;
    localparam logic [TGT_W-1:0] MAXF_RESET = 20'd100000;
    localparam logic [CLK_W:0]   WRAP_LIMIT = 29'd65536;
    localparam logic [7:0]       DUTY_FULL  = 8'd100;

    // wrap / 100 is taken as (wrap >> 2) / 25 with a reciprocal that is exact below 2^14
    localparam logic [14:0] RECIP_25 = 15'd20972;
    localparam int          RECIP_25_SHIFT = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_CLOCK = 8'd0,
        REG_MAX_FREQ     = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [TGT_W-1:0]  tgt;
        logic [DUTY_W-1:0] duty;
        logic              tgt_zero;
        logic [CLK_W-1:0]  quo;        // clock / target
        logic [TGT_W-1:0]  rem;        // clock mod target
        logic [DIV_W-1:0]  sel_div;    // zero while no divider fits
        logic [WRAP_W-1:0] best_wrap;
        logic [NUM_W-1:0]  best_num;
        logic [DEN_W-1:0]  best_den;
    } item_t;

endpackage

@@ hw/rtl/pdws_unit.sv @@
`timescale 1ns / 1ps
// One divider candidate of the PWM solver: six pipeline stages that derive quotient,
// wrap and deviation for a fixed divider and keep the better of it and the best so far.
// Depends on pdws_pkg.
module pdws_unit
    import pdws_pkg::*;
#(
    parameter int DIV_NUM  = 1,
    parameter int MIN_WRAP = DEF_MIN_WRAP
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam logic [DIV_W-1:0] DIV_V   = DIV_W'(DIV_NUM);
    localparam logic [32:0]      RECIP   = 33'((64'd1 << 32) / DIV_NUM);
    localparam logic [CLK_W-1:0] Q_FLOOR = CLK_W'(MIN_WRAP + 1);

    logic [5:0]        vld_reg;
    item_t             s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg, s5_item_reg;
    item_t             s6_item_reg;
    logic [CLK_W-1:0]  s1_qest_reg, s2_qest_reg, s2_qd_reg, s3_q_reg;
    logic [DIV_W-1:0]  s3_m_reg;
    logic              s3_ok_reg, s4_ok_reg, s5_ok_reg;
    logic [NUM_W-1:0]  s4_num_reg, s5_num_reg;
    logic [DEN_W-1:0]  s4_den_reg, s5_den_reg;
    logic [WRAP_W-1:0] s4_wrap_reg, s5_wrap_reg;
    logic [51:0]       s5_pnew_reg, s5_pbest_reg;

    logic [60:0]       recip_prod;
    logic [35:0]       qd_prod;
    logic [CLK_W-1:0]  m0;
    logic [CLK_W-1:0]  q_fix;
    logic [DIV_W-1:0]  m_fix;
    logic [CLK_W-1:0]  den_full;
    logic [CLK_W-1:0]  q_minus1;
    logic              take;
    item_t             s6_item_next;

    always_comb begin
        recip_prod = 61'(in_item.quo) * 61'(RECIP);
        qd_prod    = 36'(s1_qest_reg) * 36'(DIV_V);
        m0         = s2_item_reg.quo - s2_qd_reg;
        if (m0 >= CLK_W'(DIV_V)) begin
            q_fix = s2_qest_reg + CLK_W'(1);
            m_fix = DIV_W'(m0 - CLK_W'(DIV_V));
        end else begin
            q_fix = s2_qest_reg;
            m_fix = m0[DIV_W-1:0];
        end
        den_full = s3_item_reg.quo - CLK_W'(s3_m_reg);
        q_minus1 = s3_q_reg - CLK_W'(1);
        take = s5_ok_reg && ((s5_item_reg.sel_div == '0) || (s5_pnew_reg < s5_pbest_reg));
        s6_item_next = s5_item_reg;
        if (take) begin
            s6_item_next.sel_div   = DIV_V;
            s6_item_next.best_wrap = s5_wrap_reg;
            s6_item_next.best_num  = s5_num_reg;
            s6_item_next.best_den  = s5_den_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: quotient estimate, at most one short
            s1_item_reg  <= in_item;
            s1_qest_reg  <= recip_prod[59:32];
            // stage 2: back-multiply
            s2_item_reg  <= s1_item_reg;
            s2_qest_reg  <= s1_qest_reg;
            s2_qd_reg    <= qd_prod[CLK_W-1:0];
            // stage 3: correct quotient, residue and range check
            s3_item_reg  <= s2_item_reg;
            s3_q_reg     <= q_fix;
            s3_m_reg     <= m_fix;
            s3_ok_reg    <= !s2_item_reg.tgt_zero && (q_fix > Q_FLOOR)
                            && ({1'b0, q_fix} <= WRAP_LIMIT);
            // stage 4: deviation numerator and denominator
            s4_item_reg  <= s3_item_reg;
            s4_ok_reg    <= s3_ok_reg;
            s4_num_reg   <= NUM_W'(s3_item_reg.rem) + NUM_W'(s3_item_reg.tgt) * NUM_W'(s3_m_reg);
            s4_den_reg   <= den_full[DEN_W-1:0];
            s4_wrap_reg  <= q_minus1[WRAP_W-1:0];
            // stage 5: cross products
            s5_item_reg  <= s4_item_reg;
            s5_ok_reg    <= s4_ok_reg;
            s5_num_reg   <= s4_num_reg;
            s5_den_reg   <= s4_den_reg;
            s5_wrap_reg  <= s4_wrap_reg;
            s5_pnew_reg  <= 52'(s4_num_reg) * 52'(s4_item_reg.best_den);
            s5_pbest_reg <= 52'(s4_item_reg.best_num) * 52'(s4_den_reg);
            // stage 6: keep the nearer one, the smaller divider on a tie
            s6_item_reg  <= s6_item_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = s6_item_reg;

endmodule

@@ hw/rtl/pwm_divider_wrap_duty_solver.sv @@
`timescale 1ns / 1ps
// Top level of the PWM divider/wrap solver: input clamp, bit-serial clock/target
// division, the chain of divider candidates and the output skid stage.
// Depends on pdws_pkg and pdws_unit.
//
// Usage:
//   s_ channel: one request per handshake, tdata = target_freq_hz[31:0], duty_percent[39:32].
//   m_ channel: one result per request, in request order; tdata holds clock_divider,
//   wrap_value and compare_level, tuser holds no_fit (then all tdata fields are zero).
//   cfg channel: write source_clock_hz (index 0) or max_freq_hz (index 1); always ready.
//   Write it only while no request is in flight.
// Throughput: one request per cycle while s_tready is high. Pipeline from request to result:
// 1 clamp stage, 28 one-bit division stages, six stages per divider candidate,
// two compare-level stages, one output register.
// The divider candidates form a chain because each compares against the best so far.
// Reset: clears all valid bits and loads the registers with 125 MHz and 100 kHz.
// Stall: when m_tready is low, the next finished result parks in a skid register;
// s_tready drops only once that register is full, and nothing is lost or repeated.
module pwm_divider_wrap_duty_solver
    import pdws_pkg::*;
#(
    parameter int MAX_DIVIDER        = DEF_MAX_DIVIDER,
    parameter int MIN_WRAP_EXCLUSIVE = DEF_MIN_WRAP
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,    // target_freq_hz[31:0], duty_percent[39:32]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,    // clock_divider[4:0], wrap_value[20:5],
                                              // compare_level[36:21], zero fill[39:37]
    output logic                  m_tuser,    // no_fit
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CLK_W-1:0] clk_hz_reg;
    logic [TGT_W-1:0] maxf_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_RESET;
            maxf_reg   <= MAXF_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SOURCE_CLOCK: clk_hz_reg <= cfg_data[CLK_W-1:0];
                REG_MAX_FREQ:     maxf_reg   <= cfg_data[TGT_W-1:0];
                default: ;   // drop writes outside the register list
            endcase
        end
    end

    // whole pipeline advances while the skid register is empty
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage 0: clamp target and duty, seed the search record
    logic [31:0]       in_tgt;
    logic [7:0]        in_duty;
    item_t             in_item;

    always_comb begin
        in_tgt  = s_tdata[31:0];
        in_duty = s_tdata[39:32];
        in_item = '0;
        in_item.tgt      = (in_tgt > 32'(maxf_reg)) ? maxf_reg : in_tgt[TGT_W-1:0];
        in_item.duty     = (in_duty > DUTY_FULL) ? DUTY_FULL[DUTY_W-1:0] : in_duty[DUTY_W-1:0];
        in_item.tgt_zero = (in_item.tgt == '0);
        in_item.best_den = DEN_W'(1);
    end

    // division stages: one quotient bit of clock / target each
    logic  div_valid_reg [0:CLK_W];
    item_t div_item_reg  [0:CLK_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en) begin
            div_valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_item_reg[0] <= in_item;
        end
    end

    for (genvar k = 0; k < CLK_W; k++) begin : g_div
        logic [TGT_W:0] trial;
        item_t          step_next;

        always_comb begin
            trial     = {div_item_reg[k].rem, clk_hz_reg[CLK_W-1-k]};
            step_next = div_item_reg[k];
            if (trial >= {1'b0, div_item_reg[k].tgt}) begin
                step_next.rem = TGT_W'(trial - {1'b0, div_item_reg[k].tgt});
                step_next.quo = {div_item_reg[k].quo[CLK_W-2:0], 1'b1};
            end else begin
                step_next.rem = trial[TGT_W-1:0];
                step_next.quo = {div_item_reg[k].quo[CLK_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_item_reg[k+1] <= step_next;
            end
        end
    end

    // divider candidates, smallest first
    logic  cand_valid [0:MAX_DIVIDER];
    item_t cand_item  [0:MAX_DIVIDER];

    assign cand_valid[0] = div_valid_reg[CLK_W];
    assign cand_item[0]  = div_item_reg[CLK_W];

    for (genvar d = 0; d < MAX_DIVIDER; d++) begin : g_cand
        pdws_unit #(
            .DIV_NUM  (d + 1),
            .MIN_WRAP (MIN_WRAP_EXCLUSIVE)
        ) u_cand (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cand_valid[d]),
            .in_item   (cand_item[d]),
            .out_valid (cand_valid[d+1]),
            .out_item  (cand_item[d+1])
        );
    end

    // output stage 1: wrap / 100, zero when no divider fits
    item_t             fin;
    logic [29:0]       wq_prod;
    logic              o1_valid_reg, o1_nofit_reg;
    logic [4:0]        o1_div_reg;
    logic [WRAP_W-1:0] o1_wrap_reg;
    logic [9:0]        o1_wq_reg;
    logic [DUTY_W-1:0] o1_duty_reg;

    assign fin     = cand_item[MAX_DIVIDER];
    assign wq_prod = 30'(fin.best_wrap[WRAP_W-1:2]) * 30'(RECIP_25);

    // output stage 2: compare level
    logic        o2_valid_reg, o2_nofit_reg;
    logic [36:0] o2_data_reg;
    logic [16:0] cmp_prod;

    assign cmp_prod = 17'(o1_wq_reg) * 17'(o1_duty_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o1_valid_reg <= 1'b0;
            o2_valid_reg <= 1'b0;
        end else if (en) begin
            o1_valid_reg <= cand_valid[MAX_DIVIDER];
            o2_valid_reg <= o1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o1_nofit_reg <= (fin.sel_div == '0);
            o1_div_reg   <= fin.sel_div[4:0];
            o1_wrap_reg  <= fin.best_wrap;
            o1_wq_reg    <= (fin.sel_div == '0) ? 10'd0 : wq_prod[RECIP_25_SHIFT +: 10];
            o1_duty_reg  <= fin.duty;
            o2_nofit_reg <= o1_nofit_reg;
            o2_data_reg  <= o1_nofit_reg ? 37'd0
                                         : {cmp_prod[15:0], o1_wrap_reg, o1_div_reg};
        end
    end

    // output register and skid register
    logic        m_valid_reg, m_valid_next;
    logic [36:0] m_data_reg, m_data_next, skid_data_reg, skid_data_next;
    logic        m_nofit_reg, m_nofit_next, skid_nofit_reg, skid_nofit_next;
    logic        skid_valid_next;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_nofit_next    = m_nofit_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_nofit_next = skid_nofit_reg;
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // drain the parked result first
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                m_nofit_next    = skid_nofit_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = o2_valid_reg;
                m_data_next  = o2_data_reg;
                m_nofit_next = o2_nofit_reg;
            end
        end else if (en && o2_valid_reg) begin
            // receiver stalls: park the result that leaves the pipe now
            skid_valid_next = 1'b1;
            skid_data_next  = o2_data_reg;
            skid_nofit_next = o2_nofit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        m_nofit_reg    <= m_nofit_next;
        skid_data_reg  <= skid_data_next;
        skid_nofit_reg <= skid_nofit_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};
    assign m_tuser  = m_nofit_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_nofit_reg) |-> (m_data_reg == '0))
        else $error("no_fit result carries nonzero fields");

    a_wrap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_nofit_reg) |-> (m_data_reg[20:5] > 16'(MIN_WRAP_EXCLUSIVE)))
        else $error("chosen wrap outside the valid range");

    a_cmp_le_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_nofit_reg) |-> (m_data_reg[36:21] <= m_data_reg[20:5]))
        else $error("compare level above wrap");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && !skid_valid_reg && o2_valid_reg) |=> skid_valid_reg)
        else $error("result leaving the pipe during a stall was not parked");
`endif

endmodule
